[hw/rtl/mlu_pkg.sv]
package mlu_pkg;

	localparam int DEF_MAX_X_POINTS = 16;
	localparam int DEF_MAX_Y_POINTS = 16;

	localparam int VAL_W = 16;
	localparam int QUO_W = 16;
	localparam int DEN_W = 32;
	localparam int NUM_W = DEN_W + QUO_W;

	typedef enum logic [1:0] {
		OP_QUERY   = 2'd0,
		OP_WR_X    = 2'd1,
		OP_WR_Y    = 2'd2,
		OP_WR_GRID = 2'd3
	} op_t;

	localparam logic [0:0] CFG_X_POINTS = 1'b0;
	localparam logic [0:0] CFG_Y_POINTS = 1'b1;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

[hw/rtl/mlu_ram.sv]
module mlu_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/mlu_div.sv]
module mlu_div import mlu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] low_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	// remainder shifted by one numerator bit, quotient bits enter low_q from the bottom
	assign trial = {rem_q, low_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CNT_W'(QUO_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[NUM_W-1:QUO_W];
			low_q <= req.num[QUO_W-1:0];
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			low_q <= {low_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = low_q;

endmodule

[hw/rtl/map_2d_interpolation_lookup_unit.sv]
// channel   | direction | signals                                    | transfer
// ----------+-----------+--------------------------------------------+-------------------------
// command   | in        | start, busy, operation, row_index,         | start && !busy
//           |           | col_index, write_value, command_x/y        |
// result    | out       | done, map_result                           | done, one cycle, no stall
// config    | in        | cfg_valid, cfg_ready, cfg_index, cfg_data  | cfg_valid && cfg_ready
//
// writes of breakpoints or grid values go straight to memory and leave busy low.
// a query runs longer for an inner cell than for corners and edges; its length is set by
// the sequential axis scans (one breakpoint read per cycle) and the 16-step divider.
// arst_n clears the sequencer and the point counts (both 1); memories are not cleared.
// results cannot be held off: done pulses for one cycle and the next word may start then.
module map_2d_interpolation_lookup_unit import mlu_pkg::*; #(
	parameter int MAX_X_POINTS = DEF_MAX_X_POINTS,
	parameter int MAX_Y_POINTS = DEF_MAX_Y_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [3:0]         row_index,
	input  logic [3:0]         col_index,
	input  logic signed [16:0] write_value,
	input  logic signed [15:0] command_x,
	input  logic signed [15:0] command_y,
	output logic               done,
	output logic [15:0]        map_result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [4:0]         cfg_data
);

	localparam int XW     = $clog2(MAX_X_POINTS);
	localparam int YW     = $clog2(MAX_Y_POINTS);
	localparam int AW     = (XW > YW) ? XW : YW;
	localparam int MAXP   = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
	localparam int CW     = $clog2(MAXP + 1) + 1;
	localparam int LXW    = $clog2(MAX_X_POINTS + 1);
	localparam int LYW    = $clog2(MAX_Y_POINTS + 1);
	localparam int GDEPTH = MAX_X_POINTS * MAX_Y_POINTS;
	localparam int GAW    = $clog2(GDEPTH);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ENDS,
		S_DECIDE,
		S_SCAN,
		S_GRID,
		S_SETUP,
		S_MUL,
		S_ACC,
		S_DIV
	} state_t;

	typedef enum logic [1:0] {
		M_CORNER,
		M_XLERP,
		M_YLERP,
		M_BILIN
	} mode_t;

	state_t state_q;
	mode_t  mode_q;

	logic [4:0] x_used_q, y_used_q;
	logic [LXW-1:0] lx;
	logic [LYW-1:0] ly;
	logic [XW-1:0] xl;
	logic [YW-1:0] yl;

	logic accept;
	logic row_ok, col_ok;

	logic          axis_we;
	logic [AW:0]   axis_waddr, axis_raddr;
	logic [15:0]   axis_rdata;
	logic          grid_we;
	logic [GAW-1:0] grid_waddr, grid_raddr;
	logic [15:0]   grid_rdata;

	logic [CW-1:0] cnt_q;
	logic signed [15:0] cx_q, cy_q;
	logic signed [15:0] xf_q, xe_q, yf_q, ye_q;
	logic signed [15:0] prev_q;
	logic signed [15:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;
	logic [XW-1:0] ix_q, gr_q;
	logic [YW-1:0] iy_q, gc_q;
	logic          scan_y_q, hit_q;
	logic [15:0]   g_q [4];
	logic [15:0]   w_q [4];
	logic [15:0]   dx_q, dy_q, dqm_q, off_q;
	logic          neg_q, bil_q;
	logic [2:0]    st_q;
	logic [NUM_W-1:0] prod_q, acc_q, num_q;
	logic [DEN_W-1:0] a_q, den_q;
	logic          div_go_q;
	logic          done_q;
	logic [15:0]   map_result_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_used_q <= 5'd1;
			y_used_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_X_POINTS: x_used_q <= cfg_data;
				CFG_Y_POINTS: y_used_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (x_used_q == '0) lx = LXW'(1);
		else if (int'(x_used_q) > MAX_X_POINTS) lx = LXW'(MAX_X_POINTS);
		else lx = LXW'(x_used_q);
		if (y_used_q == '0) ly = LYW'(1);
		else if (int'(y_used_q) > MAX_Y_POINTS) ly = LYW'(MAX_Y_POINTS);
		else ly = LYW'(y_used_q);
	end

	assign xl = XW'(lx - LXW'(1));
	assign yl = YW'(ly - LYW'(1));

	// writes go straight to memory on the accepting edge
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign row_ok = int'(row_index) < MAX_X_POINTS;
	assign col_ok = int'(col_index) < MAX_Y_POINTS;

	assign axis_we = accept && (((operation == OP_WR_X) && row_ok) ||
		((operation == OP_WR_Y) && col_ok));
	assign axis_waddr = (operation == OP_WR_X) ? {1'b0, AW'(row_index)} :
		{1'b1, AW'(col_index)};
	assign grid_we    = accept && (operation == OP_WR_GRID) && row_ok && col_ok;
	assign grid_waddr = GAW'(int'(row_index) * MAX_Y_POINTS + int'(col_index));

	mlu_ram #(.DEPTH(2 * (2 ** AW)), .WIDTH(VAL_W)) u_axis_ram (
		.clk   (clk),
		.we    (axis_we),
		.waddr (axis_waddr),
		.wdata (write_value[15:0]),
		.raddr (axis_raddr),
		.rdata (axis_rdata)
	);

	mlu_ram #(.DEPTH(GDEPTH), .WIDTH(VAL_W)) u_grid_ram (
		.clk   (clk),
		.we    (grid_we),
		.waddr (grid_waddr),
		.wdata (write_value[15:0]),
		.raddr (grid_raddr),
		.rdata (grid_rdata)
	);

	// axis read address
	always_comb begin
		axis_raddr = '0;
		if (state_q == S_ENDS) begin
			unique case (cnt_q[1:0])
				2'd0: axis_raddr = {1'b0, AW'(0)};
				2'd1: axis_raddr = {1'b0, AW'(xl)};
				2'd2: axis_raddr = {1'b1, AW'(0)};
				2'd3: axis_raddr = {1'b1, AW'(yl)};
				default: axis_raddr = '0;
			endcase
		end else if (state_q == S_SCAN) begin
			axis_raddr = {scan_y_q, AW'(cnt_q)};
		end
	end

	// scan compare: interval cnt-2 lies between prev_q and the word just read
	logic signed [15:0] scan_c;
	logic signed [15:0] scan_cur;
	logic [CW-1:0]      scan_len;
	logic               scan_match;
	logic [CW-1:0]      scan_idx;

	assign scan_c     = scan_y_q ? cy_q : cx_q;
	assign scan_cur   = $signed(axis_rdata);
	assign scan_len   = scan_y_q ? CW'(ly) : CW'(lx);
	assign scan_idx   = cnt_q - CW'(2);
	assign scan_match = (cnt_q >= CW'(2)) && (prev_q <= scan_c) && (scan_c <= scan_cur);

	// grid read address
	logic [XW-1:0] g_row;
	logic [YW-1:0] g_col;
	logic [XW-1:0] base_row;
	logic [YW-1:0] base_col;
	logic [CW-1:0] g_reads;
	logic          dr, dc;

	always_comb begin
		base_row = ((mode_q == M_XLERP) || (mode_q == M_BILIN)) ? ix_q : gr_q;
		base_col = ((mode_q == M_YLERP) || (mode_q == M_BILIN)) ? iy_q : gc_q;
		dr       = cnt_q[0] && (mode_q != M_YLERP) && (mode_q != M_CORNER);
		dc       = (mode_q == M_YLERP) ? cnt_q[0] : (cnt_q[1] && (mode_q == M_BILIN));
		g_row    = base_row + XW'(dr);
		g_col    = base_col + YW'(dc);
		unique case (mode_q)
			M_CORNER: g_reads = CW'(1);
			M_BILIN:  g_reads = CW'(4);
			default:  g_reads = CW'(2);
		endcase
	end

	assign grid_raddr = GAW'(int'(g_row) * MAX_Y_POINTS + int'(g_col));

	// interpolation setup
	logic signed [16:0] dxs, dys, ld, lva, dq;
	logic               sel_y, bil_full, direct;
	logic signed [15:0] lv, la0, la1;
	logic [15:0]        lq1;

	always_comb begin
		dxs      = 17'(hi_x_q) - 17'(lo_x_q);
		dys      = 17'(hi_y_q) - 17'(lo_y_q);
		bil_full = (mode_q == M_BILIN) && (dxs != '0) && (dys != '0);
		sel_y    = (mode_q == M_YLERP) || ((mode_q == M_BILIN) && (dxs == '0));
		lv       = sel_y ? cy_q : cx_q;
		la0      = sel_y ? lo_y_q : lo_x_q;
		la1      = sel_y ? hi_y_q : hi_x_q;
		lq1      = ((mode_q == M_BILIN) && (dxs == '0)) ? g_q[2] : g_q[1];
		ld       = 17'(la1) - 17'(la0);
		lva      = 17'(lv) - 17'(la0);
		dq       = $signed({1'b0, lq1}) - $signed({1'b0, g_q[0]});
		direct   = !bil_full && (ld == '0);
	end

	// shared multiplier operands
	logic [15:0]      opa;
	logic [DEN_W-1:0] opb;

	always_comb begin
		opa = w_q[0];
		opb = DEN_W'(dqm_q);
		if (bil_q) begin
			unique case (st_q)
				3'd0: begin opa = w_q[0]; opb = DEN_W'(g_q[0]); end
				3'd1: begin opa = w_q[1]; opb = DEN_W'(g_q[1]); end
				3'd2: begin opa = w_q[0]; opb = DEN_W'(g_q[2]); end
				3'd3: begin opa = w_q[1]; opb = DEN_W'(g_q[3]); end
				3'd4: begin opa = w_q[2]; opb = a_q; end
				3'd5: begin opa = w_q[3]; opb = acc_q[DEN_W-1:0]; end
				default: begin opa = dx_q; opb = DEN_W'(dy_q); end
			endcase
		end
	end

	// final offset, sign and clamp
	logic signed [17:0] fin;
	logic [15:0]        fin_sat;

	always_comb begin
		fin = $signed({2'b00, off_q}) + (neg_q ? -$signed({2'b00, div_rsp.quo}) :
			$signed({2'b00, div_rsp.quo}));
		if (fin[17]) fin_sat = 16'd0;
		else if (fin[16]) fin_sat = 16'hFFFF;
		else fin_sat = fin[15:0];
	end

	assign div_req.start = div_go_q;
	assign div_req.num   = num_q;
	assign div_req.den   = den_q;

	mlu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= M_CORNER;
			cnt_q        <= '0;
			scan_y_q     <= 1'b0;
			hit_q        <= 1'b0;
			st_q         <= '0;
			bil_q        <= 1'b0;
			div_go_q     <= 1'b0;
			done_q       <= 1'b0;
			map_result_q <= '0;
		end else begin
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (operation == OP_QUERY)) begin
						cnt_q   <= '0;
						state_q <= S_ENDS;
					end
				end
				S_ENDS: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(4)) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					cnt_q <= '0;
					hit_q <= 1'b0;
					priority if ((cx_q <= xf_q) && (cy_q <= yf_q)) begin
						mode_q <= M_CORNER; state_q <= S_GRID;
					end else if ((cx_q >= xe_q) && (cy_q <= yf_q)) begin
						mode_q <= M_CORNER; state_q <= S_GRID;
					end else if ((cx_q <= xf_q) && (cy_q >= ye_q)) begin
						mode_q <= M_CORNER; state_q <= S_GRID;
					end else if ((cx_q >= xe_q) && (cy_q >= ye_q)) begin
						mode_q <= M_CORNER; state_q <= S_GRID;
					end else if ((cy_q <= yf_q) || (cy_q >= ye_q) || (ly == LYW'(1))) begin
						mode_q   <= M_XLERP;
						scan_y_q <= 1'b0;
						state_q  <= S_SCAN;
					end else if ((cx_q <= xf_q) || (cx_q >= xe_q)) begin
						mode_q   <= M_YLERP;
						scan_y_q <= 1'b1;
						state_q  <= S_SCAN;
					end else begin
						mode_q   <= M_BILIN;
						scan_y_q <= 1'b0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + CW'(1);
					if (scan_match) begin
						hit_q <= 1'b1;
					end
					if (cnt_q == scan_len) begin
						cnt_q <= '0;
						hit_q <= 1'b0;
						if (!(hit_q || scan_match)) begin
							// no interval holds the command
							done_q       <= 1'b1;
							map_result_q <= '0;
							state_q      <= S_IDLE;
						end else if (!scan_y_q && (mode_q == M_BILIN)) begin
							scan_y_q <= 1'b1;
						end else begin
							state_q <= S_GRID;
						end
					end
				end
				S_GRID: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == g_reads) begin
						if (mode_q == M_CORNER) begin
							done_q       <= 1'b1;
							map_result_q <= grid_rdata;
							state_q      <= S_IDLE;
						end else begin
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: begin
					st_q  <= '0;
					bil_q <= bil_full;
					if (direct) begin
						done_q       <= 1'b1;
						map_result_q <= g_q[0];
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (!bil_q || (st_q == 3'd6)) begin
						div_go_q <= 1'b1;
						state_q  <= S_DIV;
					end else begin
						st_q    <= st_q + 3'd1;
						state_q <= S_MUL;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						done_q       <= 1'b1;
						map_result_q <= fin_sat;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		if (accept && (operation == OP_QUERY)) begin
			cx_q <= command_x;
			cy_q <= command_y;
		end
		if (state_q == S_ENDS) begin
			unique case (cnt_q[2:0])
				3'd1: xf_q <= $signed(axis_rdata);
				3'd2: xe_q <= $signed(axis_rdata);
				3'd3: yf_q <= $signed(axis_rdata);
				3'd4: ye_q <= $signed(axis_rdata);
				default: ;
			endcase
		end
		if (state_q == S_DECIDE) begin
			// the low end wins when a command sits at both ends
			gr_q <= (cx_q <= xf_q) ? XW'(0) : xl;
			gc_q <= ((cy_q <= yf_q) || (ly == LYW'(1))) ? YW'(0) : yl;
		end
		if (state_q == S_SCAN) begin
			prev_q <= scan_cur;
			if (scan_match) begin
				if (scan_y_q) begin
					iy_q   <= YW'(scan_idx);
					lo_y_q <= prev_q;
					hi_y_q <= scan_cur;
				end else begin
					ix_q   <= XW'(scan_idx);
					lo_x_q <= prev_q;
					hi_x_q <= scan_cur;
				end
			end
		end
		if ((state_q == S_GRID) && (cnt_q != '0)) begin
			g_q[cnt_q[1:0] - 2'd1] <= grid_rdata;
		end
		if (state_q == S_SETUP) begin
			if (bil_full) begin
				w_q[0] <= 16'(17'(hi_x_q) - 17'(cx_q));
				w_q[1] <= 16'(17'(cx_q) - 17'(lo_x_q));
				w_q[2] <= 16'(17'(hi_y_q) - 17'(cy_q));
				w_q[3] <= 16'(17'(cy_q) - 17'(lo_y_q));
				dx_q   <= dxs[15:0];
				dy_q   <= dys[15:0];
				neg_q  <= 1'b0;
				off_q  <= '0;
			end else begin
				w_q[0] <= lva[15:0];
				dx_q   <= ld[15:0];
				dqm_q  <= dq[16] ? 16'(-dq) : dq[15:0];
				neg_q  <= dq[16];
				off_q  <= g_q[0];
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= opa * opb;
		end
		if (state_q == S_ACC) begin
			if (!bil_q) begin
				num_q <= prod_q;
				den_q <= DEN_W'(dx_q);
			end else begin
				unique case (st_q)
					3'd0: acc_q <= prod_q;
					3'd1: a_q   <= DEN_W'(acc_q + prod_q);
					3'd2: acc_q <= prod_q;
					3'd3: acc_q <= acc_q + prod_q;
					3'd4: num_q <= prod_q;
					3'd5: num_q <= num_q + prod_q;
					default: den_q <= prod_q[DEN_W-1:0];
				endcase
			end
		end
	end

	assign done       = done_q;
	assign map_result = map_result_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while sequencer active");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result strobe without a query in flight");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_QUERY)) |=> busy)
		else $error("query accepted but sequencer stayed idle");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation != OP_QUERY)) |=> (!busy && !done))
		else $error("write word started work or gave a result");
`endif

endmodule
